[rtl/rtccu_pkg.sv]
// Shared types, constants and divide helpers for the RTC catch-up block.
// No dependencies; imported by every module of the block.
package rtccu_pkg;

  localparam int unsigned PaddrW = 3;
  localparam int unsigned DataW  = 32;

  localparam logic RegCurrentTime = 1'b0;

  localparam logic [7:0] RecLenCorr = 8'd9;
  localparam logic [7:0] RecLenRaw  = 8'd5;

  localparam logic [7:0] SecMax  = 8'd59;
  localparam logic [7:0] MinMax  = 8'd59;
  localparam logic [7:0] HourMax = 8'd23;

  // diff / 3600 = (diff >> 4) / 225
  localparam logic [28:0] Recip225      = 29'd305419897;
  localparam int unsigned Recip225Shift = 36;
  // (hours >> 3) / 3, 18-bit operand
  localparam logic [17:0] Recip3Wide    = 18'd174763;
  localparam int unsigned Recip3WShift  = 19;
  // (x >> 2) / 15, 10-bit operand
  localparam logic [10:0] Recip15       = 11'd1093;
  // (x >> 3) / 3, 5-bit operand
  localparam logic [3:0]  Recip3Narrow  = 4'd11;

  typedef struct packed {
    logic [7:0] seconds;
    logic [7:0] minutes;
    logic [7:0] hours;
    logic [7:0] days_lo;
    logic [7:0] days_hi;
  } rec_t;

  typedef struct packed {
    rec_t        rec;
    logic        full;
    logic        corr;
    logic [20:0] hours_total;
    logic [11:0] diff_lo;
  } split1_t;

  typedef struct packed {
    rec_t        rec;
    logic        full;
    logic        corr;
    logic [15:0] days;
    logic [4:0]  hrs;
    logic [11:0] rem;
  } split2_t;

  typedef struct packed {
    rec_t        rec;
    logic        full;
    logic        corr;
    logic [15:0] days;
    logic [4:0]  hrs;
    logic [5:0]  mins;
    logic [5:0]  secs;
  } elapsed_t;

  typedef struct packed {
    logic [7:0] seconds;
    logic [7:0] minutes;
    logic [7:0] hours;
    logic [8:0] day_count;
    logic       halted;
    logic       day_carry;
  } clock_t;

  function automatic logic [6:0] div60(input logic [11:0] x);
    logic [20:0] p;
    p = 21'(x[11:2]) * 21'(Recip15);
    return p[20:14];
  endfunction

  function automatic logic [4:0] div24(input logic [7:0] x);
    logic [9:0] p;
    p = 10'(x[7:3]) * 10'(Recip3Narrow);
    return p[9:5];
  endfunction

endpackage

[rtl/rtccu_regs.sv]
// APB-style register file holding current_time.
// Depends on rtccu_pkg.
module rtccu_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rtccu_pkg::PaddrW-1:0] paddr,
  input  logic [rtccu_pkg::DataW-1:0]  pwdata,
  output logic [rtccu_pkg::DataW-1:0]  prdata,
  output logic                        pready,
  output logic [31:0]                 current_time_o
);
  import rtccu_pkg::*;

  logic [31:0] current_time_q, current_time_d;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready && (paddr[2] == RegCurrentTime);

  always_comb begin
    current_time_d = wr_en ? pwdata : current_time_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      current_time_q <= '0;
    end else begin
      current_time_q <= current_time_d;
    end
  end

  always_comb begin
    unique case (paddr[2])
      RegCurrentTime: prdata = current_time_q;
      default:        prdata = '0;
    endcase
  end

  assign current_time_o = current_time_q;

endmodule

[rtl/rtccu_split.sv]
// Input register and three pipeline stages that split elapsed seconds
// into days, hours, minutes and seconds. Depends on rtccu_pkg.
module rtccu_split (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [31:0]         current_time_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  rtccu_pkg::rec_t     rec_i,
  input  logic [31:0]         saved_timestamp_i,
  input  logic [7:0]          record_length_i,
  output logic                elp_valid_o,
  input  logic                elp_stall_i,
  output rtccu_pkg::elapsed_t elp_o
);
  import rtccu_pkg::*;

  logic        v0_q, v1_q, v2_q, v3_q;
  logic        load0, load1, load2, load3;
  rec_t        rec0_q;
  logic [31:0] ts0_q;
  logic [7:0]  len0_q;
  split1_t     st1_q, st1_d;
  split2_t     st2_q, st2_d;
  elapsed_t    st3_q, st3_d;

  logic [31:0] diff;
  logic [56:0] prod_h;
  logic [35:0] prod_d;
  logic [20:0] days_x24;
  logic [11:0] ht_x3600;
  logic [6:0]  mins_div;
  logic [11:0] mins_x60;

  assign load3 = !v3_q || !elp_stall_i;
  assign load2 = !v2_q || load3;
  assign load1 = !v1_q || load2;
  assign load0 = !v0_q || load1;
  assign in_stall_o = !load0;

  // stage 0: saturating difference, total hours
  always_comb begin
    diff = (current_time_i > ts0_q) ? (current_time_i - ts0_q) : '0;
    prod_h = 57'(diff[31:4]) * 57'(Recip225);
    st1_d.rec         = rec0_q;
    st1_d.corr        = |current_time_i;
    st1_d.full        = len0_q >= (st1_d.corr ? RecLenCorr : RecLenRaw);
    st1_d.hours_total = prod_h[Recip225Shift +: 21];
    st1_d.diff_lo     = diff[11:0];
  end

  // stage 1: days, hours of day, seconds within the hour
  always_comb begin
    prod_d   = 36'(st1_q.hours_total[20:3]) * 36'(Recip3Wide);
    st2_d.rec  = st1_q.rec;
    st2_d.corr = st1_q.corr;
    st2_d.full = st1_q.full;
    st2_d.days = prod_d[Recip3WShift +: 16];
    days_x24   = {2'b0, st2_d.days, 3'b0} + {1'b0, st2_d.days, 4'b0};
    st2_d.hrs  = 5'(st1_q.hours_total - days_x24);
    ht_x3600   = st1_q.hours_total[11:0] * 12'd3600;
    st2_d.rem  = st1_q.diff_lo - ht_x3600;
  end

  // stage 2: minutes and leftover seconds
  always_comb begin
    mins_div   = div60(st2_q.rem);
    mins_x60   = 12'(mins_div) * 12'd60;
    st3_d.rec  = st2_q.rec;
    st3_d.corr = st2_q.corr;
    st3_d.full = st2_q.full;
    st3_d.days = st2_q.days;
    st3_d.hrs  = st2_q.hrs;
    st3_d.mins = mins_div[5:0];
    st3_d.secs = 6'(st2_q.rem - mins_x60);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (load0) v0_q <= in_valid_i;
      if (load1) v1_q <= v0_q;
      if (load2) v2_q <= v1_q;
      if (load3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load0 && in_valid_i) begin
      rec0_q <= rec_i;
      ts0_q  <= saved_timestamp_i;
      len0_q <= record_length_i;
    end
    if (load1 && v0_q) st1_q <= st1_d;
    if (load2 && v1_q) st2_q <= st2_d;
    if (load3 && v2_q) st3_q <= st3_d;
  end

  assign elp_valid_o = v3_q;
  assign elp_o       = st3_q;

endmodule

[rtl/rtccu_merge.sv]
// Adds elapsed time to the record, normalizes, keeps the held clock and
// drives the result register. Depends on rtccu_pkg.
module rtccu_merge (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                elp_valid_i,
  output logic                elp_stall_o,
  input  rtccu_pkg::elapsed_t elp_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output rtccu_pkg::clock_t   clock_o
);
  import rtccu_pkg::*;

  logic        out_valid_q;
  clock_t      out_q, held_q, fixed, result;
  logic        load_out;

  logic [15:0] nd;
  logic        day_ovf;
  logic [1:0]  flags;
  logic [13:0] d14;
  logic [7:0]  sec_a, min_a, hr_a, min_b, hr_b;
  logic [6:0]  sec_div, min_div;
  logic [4:0]  hr_div;
  logic [7:0]  sec_div_x60, min_div_x60, hr_div_x24;
  logic        sec_over, min_over, hr_over, cnt_over;
  logic [14:0] d15;

  assign load_out    = !out_valid_q || !out_stall_i;
  assign elp_stall_o = !load_out;

  always_comb begin
    nd      = {7'b0, elp_i.rec.days_hi[0], elp_i.rec.days_lo} + elp_i.days;
    day_ovf = |nd[15:14];
    flags   = day_ovf ? 2'b11 : elp_i.rec.days_hi[7:6];
    d14     = day_ovf ? '0 : nd[13:0];

    sec_a = elp_i.rec.seconds + {2'b0, elp_i.secs};
    min_a = elp_i.rec.minutes + {2'b0, elp_i.mins};
    hr_a  = elp_i.rec.hours + {3'b0, elp_i.hrs};

    sec_over    = sec_a > SecMax;
    sec_div     = div60({4'b0, sec_a});
    sec_div_x60 = 8'(sec_div) * 8'd60;

    min_b       = min_a + {7'b0, sec_over};
    min_over    = min_b > MinMax;
    min_div     = div60({4'b0, min_b});
    min_div_x60 = 8'(min_div) * 8'd60;

    hr_b       = hr_a + {7'b0, min_over};
    hr_over    = hr_b > HourMax;
    hr_div     = div24(hr_b);
    hr_div_x24 = {3'b0, hr_div} * 8'd24;

    d15      = {1'b0, d14} + {14'b0, hr_over};
    cnt_over = |d15[13:9];

    fixed.seconds   = sec_a - sec_div_x60;
    fixed.minutes   = min_b - min_div_x60;
    fixed.hours     = hr_b - hr_div_x24;
    fixed.day_count = cnt_over ? '0 : d15[8:0];
    fixed.halted    = cnt_over | flags[0];
    fixed.day_carry = cnt_over | flags[1];

    if (!elp_i.full) begin
      result = held_q;
    end else if (elp_i.corr) begin
      result = fixed;
    end else begin
      result.seconds   = elp_i.rec.seconds;
      result.minutes   = elp_i.rec.minutes;
      result.hours     = elp_i.rec.hours;
      result.day_count = {elp_i.rec.days_hi[0], elp_i.rec.days_lo};
      result.halted    = elp_i.rec.days_hi[6];
      result.day_carry = elp_i.rec.days_hi[7];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      held_q      <= '0;
    end else if (load_out) begin
      out_valid_q <= elp_valid_i;
      if (elp_valid_i) held_q <= result;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out && elp_valid_i) out_q <= result;
  end

  assign out_valid_o = out_valid_q;
  assign clock_o     = out_q;

endmodule

[rtl/rtc_elapsed_time_catchup.sv]
// Top level of the RTC catch-up block; depends on rtccu_pkg, rtccu_regs,
// rtccu_split and rtccu_merge.
// A transaction passes the split input register and stages, then the merge
// result register. Throughput: one transaction per cycle unless out_stall_i
// holds a result; stages hold items independently, so stalls only back up full stages.
// Reset clears current_time, the held clock and all stage valid bits.
module rtc_elapsed_time_catchup (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rtccu_pkg::PaddrW-1:0] paddr,
  input  logic [rtccu_pkg::DataW-1:0]  pwdata,
  output logic [rtccu_pkg::DataW-1:0]  prdata,
  output logic                        pready,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [7:0]                  saved_seconds_i,
  input  logic [7:0]                  saved_minutes_i,
  input  logic [7:0]                  saved_hours_i,
  input  logic [7:0]                  days_low_byte_i,
  input  logic [7:0]                  days_high_byte_i,
  input  logic [31:0]                 saved_timestamp_i,
  input  logic [7:0]                  record_length_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [7:0]                  clock_seconds_o,
  output logic [7:0]                  clock_minutes_o,
  output logic [7:0]                  clock_hours_o,
  output logic [8:0]                  day_count_o,
  output logic                        halted_o,
  output logic                        day_carry_o
);
  import rtccu_pkg::*;

  logic [31:0] current_time;
  rec_t        rec;
  elapsed_t    elp;
  logic        elp_valid, elp_stall;
  clock_t      clock;

  assign rec.seconds = saved_seconds_i;
  assign rec.minutes = saved_minutes_i;
  assign rec.hours   = saved_hours_i;
  assign rec.days_lo = days_low_byte_i;
  assign rec.days_hi = days_high_byte_i;

  rtccu_regs u_regs (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .current_time_o (current_time)
  );

  rtccu_split u_split (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .current_time_i    (current_time),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .rec_i             (rec),
    .saved_timestamp_i (saved_timestamp_i),
    .record_length_i   (record_length_i),
    .elp_valid_o       (elp_valid),
    .elp_stall_i       (elp_stall),
    .elp_o             (elp)
  );

  rtccu_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .elp_valid_i (elp_valid),
    .elp_stall_o (elp_stall),
    .elp_i       (elp),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .clock_o     (clock)
  );

  assign clock_seconds_o = clock.seconds;
  assign clock_minutes_o = clock.minutes;
  assign clock_hours_o   = clock.hours;
  assign day_count_o     = clock.day_count;
  assign halted_o        = clock.halted;
  assign day_carry_o     = clock.day_carry;

endmodule

[rtl/rtccu_check.sv]
// Port-level checker for rtc_elapsed_time_catchup and its bind.
// Depends on rtccu_pkg and the top-level port list.
module rtccu_check (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        psel,
  input logic                        penable,
  input logic                        pwrite,
  input logic [rtccu_pkg::PaddrW-1:0] paddr,
  input logic [rtccu_pkg::DataW-1:0]  pwdata,
  input logic [rtccu_pkg::DataW-1:0]  prdata,
  input logic                        pready,
  input logic                        in_valid_i,
  input logic                        in_stall_o,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [7:0]                  clock_seconds_o,
  input logic [7:0]                  clock_minutes_o,
  input logic [7:0]                  clock_hours_o,
  input logic [8:0]                  day_count_o
);
  import rtccu_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(clock_seconds_o)
      && $stable(clock_minutes_o) && $stable(clock_hours_o) && $stable(day_count_o))
    else $error("stalled result changed");

  a_stall_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output backpressure");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) ##1 !out_stall_i ##1 !out_stall_i ##1 !out_stall_i
      ##1 !out_stall_i |=> out_valid_o)
    else $error("result missing after pipeline latency");

  a_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (psel && penable && pwrite && pready && (paddr[2] == RegCurrentTime))
      ##1 (psel && !pwrite && (paddr[2] == RegCurrentTime)) |-> prdata == $past(pwdata))
    else $error("current_time readback mismatch");

endmodule

bind rtc_elapsed_time_catchup rtccu_check u_check (.*);
